>>> rtl/u16u8_pkg.sv
// u16u8_pkg: beat types, job descriptor and byte encoding helpers for the
// utf-16 to utf-8 encoder; no dependencies
package u16u8_pkg;

    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAX_BYTES   = 6;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned SURR_W      = 10;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hd800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hdbff;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hdc00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hdfff;
    localparam logic [UNIT_W-1:0] ONE_MAX    = 16'h007f;
    localparam logic [UNIT_W-1:0] TWO_MAX    = 16'h07ff;

    localparam logic [BYTE_W-1:0] LEAD2 = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'hf0;
    localparam logic [BYTE_W-1:0] CONT  = 8'h80;

    // top bits of a high surrogate
    localparam logic [5:0] HIGH_TAG = 6'b110110;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_unit;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              text_end;
    } t_out_beat;

    // all bytes caused by one accepted unit
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]               count;
        logic                             last;
    } t_job;

    // handshake between queue and back end
    typedef struct packed {
        logic full;
        logic avail;
    } t_qstat;

    typedef struct packed {
        logic [2:0][BYTE_W-1:0] b;
        logic [1:0]             len;
    } t_enc;

    function automatic t_enc encode_bmp(input logic [UNIT_W-1:0] cp);
        t_enc e;
        e.b = '0;
        if (cp <= ONE_MAX) begin
            e.b[0] = cp[7:0];
            e.len  = 2'd1;
        end else if (cp <= TWO_MAX) begin
            e.b[0] = LEAD2 | {3'b000, cp[10:6]};
            e.b[1] = CONT | {2'b00, cp[5:0]};
            e.len  = 2'd2;
        end else begin
            e.b[0] = LEAD3 | {4'b0000, cp[15:12]};
            e.b[1] = CONT | {2'b00, cp[11:6]};
            e.b[2] = CONT | {2'b00, cp[5:0]};
            e.len  = 2'd3;
        end
        return e;
    endfunction

endpackage

>>> rtl/utf16_to_utf8_encoder.sv
// utf16_to_utf8_encoder: top level, front end, job queue and byte back end
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
//
// Takes one utf-16 code unit per input beat and sends its utf-8 bytes, one
// byte per output beat. A unit gives 1 to 3 bytes; a high surrogate is held
// (no bytes) and the following low surrogate brings out all 4 bytes of the
// supplementary code point. An unpaired held surrogate goes out as 3 bytes
// ahead of the next unit's bytes, so one unit may give up to 6 bytes; a high
// surrogate flagged last_unit is sent at once as 3 bytes. run_end marks the
// last byte caused by a unit, text_end the last byte of the string. The
// output port sustains one byte per cycle while the receiver does not stall
// and the queue holds jobs; the back end's single byte lane sets that rate.
// The front end takes a unit every cycle while the two-entry job queue has
// room, and input stall rises only when the queue is full. A unit's bytes
// pass through the job queue, the back end's job register and the output
// register. Reset is synchronous and active low and clears any held surrogate.
module utf16_to_utf8_encoder import u16u8_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    // output channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic   in_accept;
    logic   push;
    logic   pop;
    logic   held;
    t_job   front_job;
    t_job   head_job;
    t_qstat qstat;

    // stall depends on queue state only, never on valid
    assign o_in_stall = qstat.full;
    assign in_accept  = i_in_valid && !qstat.full;

    // classify the unit, pair surrogates, build the byte job
    u16u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_data),
        .o_push   (push),
        .o_job    (front_job),
        .o_held   (held)
    );

    // decouples the unit rate from the byte rate
    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (qstat)
    );

    // one byte per beat, output register parts it from the downstream stall
    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // end of string only ever lands on the end of a run
    a_text_end_on_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.text_end || o_out_data.run_end))
        else $error("text_end without run_end");

    // a flagged last unit leaves nothing held
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.last_unit) |=> !held)
        else $error("surrogate still held after last unit");

    // every queued job carries one to six bytes
    a_job_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((front_job.count != '0) && (front_job.count <= COUNT_W'(MAX_BYTES))))
        else $error("job byte count out of range");

    // the back end never pulls from an empty queue, the front never fills a full one
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pop || qstat.avail) && (!push || !qstat.full))
        else $error("queue overrun or underrun");

endmodule

>>> rtl/u16u8_front.sv
// u16u8_front: classifies code units, holds a pending high surrogate and
// builds one byte job per unit; depends on u16u8_pkg
module u16u8_front import u16u8_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    output logic     o_push,
    output t_job     o_job,
    output logic     o_held
);

    logic              r_held;
    logic [SURR_W-1:0] r_surr;
    logic              n_held;
    logic [SURR_W-1:0] n_surr;

    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        emit_unit;
    logic [10:0] plane;
    logic [20:0] cp4;
    t_enc        enc_held;
    t_enc        enc_unit;
    t_job        job;

    assign is_high   = (i_beat.code_unit >= HIGH_FIRST) && (i_beat.code_unit <= HIGH_LAST);
    assign is_low    = (i_beat.code_unit >= LOW_FIRST) && (i_beat.code_unit <= LOW_LAST);
    assign pair      = r_held && is_low;
    assign emit_unit = !(is_high && !i_beat.last_unit);

    // 0x10000 + (hi << 10) + lo
    assign plane = {1'b0, r_surr} + 11'd64;
    assign cp4   = {plane, i_beat.code_unit[SURR_W-1:0]};

    assign enc_held = encode_bmp({HIGH_TAG, r_surr});
    assign enc_unit = encode_bmp(i_beat.code_unit);

    always_comb begin
        job       = '0;
        job.last  = i_beat.last_unit;
        if (pair) begin
            job.bytes[0] = LEAD4 | {5'b00000, cp4[20:18]};
            job.bytes[1] = CONT | {2'b00, cp4[17:12]};
            job.bytes[2] = CONT | {2'b00, cp4[11:6]};
            job.bytes[3] = CONT | {2'b00, cp4[5:0]};
            job.count    = COUNT_W'(4);
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (r_held) begin
                    job.bytes[i]     = enc_held.b[i];
                    job.bytes[i + 3] = enc_unit.b[i];
                end else begin
                    job.bytes[i]     = enc_unit.b[i];
                end
            end
            job.count = (r_held ? COUNT_W'(3) : '0)
                      + (emit_unit ? {1'b0, enc_unit.len} : '0);
        end
    end

    always_comb begin
        n_held = r_held;
        n_surr = r_surr;
        if (i_accept) begin
            if (!pair && is_high && !i_beat.last_unit) begin
                n_held = 1'b1;
                n_surr = i_beat.code_unit[SURR_W-1:0];
            end else begin
                n_held = 1'b0;
                n_surr = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_surr <= '0;
        end else begin
            r_held <= n_held;
            r_surr <= n_surr;
        end
    end

    assign o_push = i_accept && (job.count != '0);
    assign o_job  = job;
    assign o_held = r_held;

endmodule

>>> rtl/u16u8_queue.sv
// u16u8_queue: short job queue between front and back end
// depends on u16u8_pkg
module u16u8_queue import u16u8_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.avail = (r_count != '0);

endmodule

>>> rtl/u16u8_back.sv
// u16u8_back: walks each job one byte per beat into the output register
// depends on u16u8_pkg
module u16u8_back import u16u8_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_qstat    i_qstat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_job               r_job;
    logic               r_busy;
    logic [COUNT_W-1:0] r_idx;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic      slot_free;
    logic      emit;
    logic      last_byte;
    logic      load;
    t_out_beat beat;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign emit      = slot_free && r_busy;
    assign last_byte = (r_idx == r_job.count - COUNT_W'(1));
    assign load      = i_qstat.avail && (!r_busy || (emit && last_byte));

    always_comb begin
        beat.out_byte = r_job.bytes[r_idx];
        beat.run_end  = last_byte;
        beat.text_end = last_byte && r_job.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_busy <= !last_byte;
                r_idx  <= r_idx + COUNT_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
        if (emit) begin
            r_out <= beat;
        end
    end

    assign o_pop       = load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> bench/utf16_to_utf8_encoder_tb.sv
// utf16_to_utf8_encoder_tb: self-checking bench for the utf-16 to utf-8 encoder
// depends on u16u8_pkg and utf16_to_utf8_encoder; predicts the bytes of every
// accepted unit beat and checks each output beat against them in order
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_tb import u16u8_pkg::*; ();

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    localparam int unsigned RANDOM_UNITS = 500;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    // bytes still owed by the block, oldest first
    t_out_beat   pending_bytes[$];
    // bytes caused by the unit being predicted
    t_out_beat   unit_bytes[$];
    // predictor copy of the surrogate hold
    logic [9:0]  held_high;
    logic        held_ok;

    int          mismatch_count = 0;
    int          units_sent     = 0;
    int          burst_left     = 0;
    bit          valid_up       = 1'b0;

    t_rx_mode    rx_mode = RX_FREE;
    int unsigned rx_left = 0;
    t_out_beat   byte_want;

    utf16_to_utf8_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] b);
        t_out_beat o;
        o.out_byte = b;
        o.run_end  = 1'b0;
        o.text_end = 1'b0;
        unit_bytes = {unit_bytes, o};
    endfunction

    // utf-8 bytes of one code point, shortest form by value
    function automatic void encode_point(logic [20:0] cp);
        if (cp <= 21'(ONE_MAX)) begin
            add_byte(cp[7:0]);
        end else if (cp <= 21'(TWO_MAX)) begin
            add_byte(LEAD2 | {3'b000, cp[10:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp <= 21'h00ffff) begin
            add_byte(LEAD3 | {4'b0000, cp[15:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            add_byte(LEAD4 | {5'b00000, cp[20:18]});
            add_byte(CONT | {2'b00, cp[17:12]});
            add_byte(CONT | {2'b00, cp[11:6]});
            add_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    // works out the bytes of one accepted unit and queues them
    function automatic void predict_unit(t_in_beat b);
        logic      is_high;
        logic      is_low;
        t_out_beat tail;
        is_high = (b.code_unit >= HIGH_FIRST) && (b.code_unit <= HIGH_LAST);
        is_low  = (b.code_unit >= LOW_FIRST) && (b.code_unit <= LOW_LAST);
        unit_bytes.delete();
        if (held_ok && is_low) begin
            // pair: low ten bits of each surrogate make up the offset
            encode_point(21'h010000 + {1'b0, held_high, 10'b0}
                         + {11'b0, b.code_unit[9:0]});
            held_ok   = 1'b0;
            held_high = '0;
        end else begin
            if (held_ok) begin
                // unpaired high surrogate goes out first as three bytes
                encode_point({5'b00000, HIGH_FIRST[15:10], held_high});
                held_ok   = 1'b0;
                held_high = '0;
            end
            if (is_high && !b.last_unit) begin
                held_high = b.code_unit[9:0];
                held_ok   = 1'b1;
            end else begin
                encode_point({5'b00000, b.code_unit});
            end
        end
        if (unit_bytes.size() > 0) begin
            tail          = unit_bytes.pop_back();
            tail.run_end  = 1'b1;
            tail.text_end = b.last_unit;
            unit_bytes    = {unit_bytes, tail};
        end
        pending_bytes = {pending_bytes, unit_bytes};
    endfunction

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------

    task automatic lower_valid();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // one unit beat; idles between bursts of random length
    task automatic send_unit(input logic [15:0] unit, input logic is_last);
        t_in_beat b;
        int       gap;
        b.code_unit = unit;
        b.last_unit = is_last;
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        valid_up = 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_unit(b);
        units_sent++;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            lower_valid();
            repeat (gap) @(posedge i_clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // hold the sender off until every owed byte has come out
    task automatic wait_drained();
        lower_valid();
        @(posedge i_clk);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // receiver side: stall pattern switches between randomly drawn modes
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:     i_out_stall <= 1'b0;
            RX_RANDOM:   i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_out_stall <= (rx_left[2:0] < 3'd3);
            default:     i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // checks each output beat against the oldest owed byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("out_byte: expected none, got %h", o_out_data.out_byte);
                mismatch_count++;
            end else begin
                byte_want = pending_bytes.pop_front();
                if (o_out_data.out_byte !== byte_want.out_byte) begin
                    $error("out_byte: expected %h, got %h",
                           byte_want.out_byte, o_out_data.out_byte);
                    mismatch_count++;
                end
                if (o_out_data.run_end !== byte_want.run_end) begin
                    $error("run_end: expected %b, got %b",
                           byte_want.run_end, o_out_data.run_end);
                    mismatch_count++;
                end
                if (o_out_data.text_end !== byte_want.text_end) begin
                    $error("text_end: expected %b, got %b",
                           byte_want.text_end, o_out_data.text_end);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // range boundaries of one, two and three byte forms
    task automatic test_length_edges();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hffff, 1'b1);
    endtask

    // lowest and highest supplementary points
    task automatic test_surrogate_pairs();
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b1);
    endtask

    // held high surrogate met by something other than a low surrogate
    task automatic test_unpaired_high();
        send_unit(16'hd812, 1'b0);
        send_unit(16'h0041, 1'b0);
        // three bytes for the stray surrogate plus three for the unit: six beats
        send_unit(16'hdabc, 1'b0);
        send_unit(16'hffff, 1'b0);
        // high after high: first goes out, second is held and then paired
        send_unit(16'hd900, 1'b0);
        send_unit(16'hdb00, 1'b0);
        send_unit(16'hdc55, 1'b1);
    endtask

    // high surrogate on the last unit is flushed, not held
    task automatic test_high_at_end();
        send_unit(16'hdbff, 1'b1);
    endtask

    // low surrogates with nothing held
    task automatic test_lone_low();
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdfff, 1'b1);
    endtask

    // mostly well-formed strings with random content, some noise between
    task automatic test_random_text();
        int          str_len;
        int          kind;
        logic        tail;
        logic [15:0] u;
        while (units_sent < RANDOM_UNITS) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any unit at all, stray surrogates included
                u = 16'($urandom_range(0, 16'hffff));
                if ($urandom_range(0, 1) == 0)
                    u = {6'($urandom_range(16'hd800 >> 10, 16'hdfff >> 10)),
                         10'($urandom_range(0, 10'h3ff))};
                send_unit(u, 1'($urandom_range(0, 3) == 0));
            end else begin
                str_len = $urandom_range(1, 10);
                for (int i = 0; i < str_len; i++) begin
                    tail = (i == str_len - 1);
                    kind = $urandom_range(0, 4);
                    case (kind)
                        0: send_unit(16'($urandom_range(0, 16'h007f)), tail);
                        1: send_unit(16'($urandom_range(16'h0080, 16'h07ff)), tail);
                        2: send_unit(16'($urandom_range(16'h0800, 16'hd7ff)), tail);
                        3: send_unit(16'($urandom_range(16'he000, 16'hffff)), tail);
                        default: begin
                            send_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
                            send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), tail);
                        end
                    endcase
                end
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial begin
        held_high = '0;
        held_ok   = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_edges();
        test_surrogate_pairs();
        test_unpaired_high();
        test_high_at_end();
        test_lone_low();
        // sender holds off until the block has emptied
        wait_drained();
        test_random_text();

        // close any open string so no surrogate is left held
        send_unit(16'h000a, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
